/* rtl/core/bgcd_pkg.sv */
// Shared types and constants for the binary GCD block.
// Depends on nothing; every other file of the block imports it.
package bgcd_pkg;

   localparam int FIELD_W     = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               trivial;
      logic [FIELD_W-1:0] opa;
      logic [FIELD_W-1:0] opb;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMMON,
      ST_REDUCE,
      ST_SCALE
   } back_state_type;

endpackage

/* rtl/core/bgcd_front.sv */
// Front end: masks the operands of an accepted word and flags the zero cases.
// Depends on bgcd_pkg.
module bgcd_front #(
   parameter int WIDTH = 32
) (
   input  logic                            start,
   input  logic [bgcd_pkg::FIELD_W-1:0]    req_operand_a,
   input  logic [bgcd_pkg::FIELD_W-1:0]    req_operand_b,
   input  bgcd_pkg::qstat_type             qstat,
   output logic                            push,
   output bgcd_pkg::job_type               job
);
   import bgcd_pkg::*;

   localparam int KEEP = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
   localparam logic [FIELD_W-1:0] IN_MASK = {FIELD_W{1'b1}} >> (FIELD_W - KEEP);

   logic [FIELD_W-1:0] opa;
   logic [FIELD_W-1:0] opb;

   always_comb begin
      opa         = req_operand_a & IN_MASK;
      opb         = req_operand_b & IN_MASK;
      job.opa     = opa;
      job.opb     = opb;
      job.trivial = (opa == '0) || (opb == '0);
      push        = start && !qstat.full;
   end

endmodule

/* rtl/core/bgcd_queue.sv */
// Two-entry queue that decouples the front end from the iterating back end.
// Depends on bgcd_pkg.
module bgcd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bgcd_pkg::job_type    push_job,
   input  logic                 pop,
   output bgcd_pkg::job_type    pop_job,
   output bgcd_pkg::qstat_type  qstat
);
   import bgcd_pkg::*;

   job_type            mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      qstat.empty = (count_ff == '0);
      qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      pop_job     = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/bgcd_back.sv */
// Back end: runs Stein's iteration one shift or subtract per cycle and strobes the result.
// Depends on bgcd_pkg.
module bgcd_back #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bgcd_pkg::qstat_type           qstat,
   input  bgcd_pkg::job_type             pop_job,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [bgcd_pkg::FIELD_W-1:0]  rsp_divisor
);
   import bgcd_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [WIDTH-1:0]    x_ff;
   logic [WIDTH-1:0]    x_in;
   logic [WIDTH-1:0]    y_ff;
   logic [WIDTH-1:0]    y_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_divisor_ff;
   logic [FIELD_W-1:0]  rsp_divisor_in;
   logic                x_ge_y;
   logic [WIDTH-1:0]    diff;

   always_comb begin
      state_in       = state_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_divisor_in = rsp_divisor_ff;
      pop            = 1'b0;
      x_ge_y         = (x_ff >= y_ff);
      diff           = x_ge_y ? (x_ff - y_ff) : (y_ff - x_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               cnt_in = '0;
               if (pop_job.trivial) begin
                  x_in     = '0;
                  y_in     = WIDTH'(pop_job.opa | pop_job.opb);
                  state_in = ST_SCALE;
               end else begin
                  x_in     = WIDTH'(pop_job.opa);
                  y_in     = WIDTH'(pop_job.opb);
                  state_in = ST_COMMON;
               end
            end
         end
         ST_COMMON: begin
            if (x_ff[0] || y_ff[0]) begin
               state_in = ST_REDUCE;
            end else begin
               x_in   = x_ff >> 1;
               y_in   = y_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_REDUCE: begin
            priority if (x_ff == '0) begin
               state_in = ST_SCALE;
            end else if (!x_ff[0] || !y_ff[0]) begin
               if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end
               if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end
            end else if (x_ge_y) begin
               x_in = diff >> 1;
            end else begin
               y_in = diff >> 1;
            end
         end
         ST_SCALE: begin
            if (cnt_ff != '0) begin
               y_in   = y_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = FIELD_W'(y_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid   = rsp_valid_ff;
      rsp_divisor = rsp_divisor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      cnt_ff         <= cnt_in;
      rsp_divisor_ff <= rsp_divisor_in;
   end

endmodule

/* rtl/core/binary_gcd.sv */
// Top level of the binary GCD block: front end, two-word queue and iterating back end.
// Depends on bgcd_pkg, bgcd_front, bgcd_queue and bgcd_back.
//
//   Channel   Handshake               Payload
//   request   start, busy             req_operand_a, req_operand_b
//   result    rsp_valid (one cycle)   rsp_divisor
//
// A word is taken when start is high and busy is low; busy is high while the queue holds two words.
// The back end loads a word, halves both operands once per common factor of two, then strips
// factors of two and subtracts until one operand is zero, scales the result back up by one shift
// per common factor and presents it.
// Zero operands skip the iteration; the nonzero operand, or zero, is presented directly.
// Reset is synchronous and empties the queue and the back end.
// The result strobe lasts one cycle; the receiver cannot hold it off.
module binary_gcd #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bgcd_pkg::FIELD_W-1:0]  req_operand_a,
   input  logic [bgcd_pkg::FIELD_W-1:0]  req_operand_b,
   output logic                          rsp_valid,
   output logic [bgcd_pkg::FIELD_W-1:0]  rsp_divisor
);
   import bgcd_pkg::*;

   qstat_type  qstat;
   job_type    push_job;
   job_type    pop_job;
   logic       push;
   logic       pop;

   assign busy = qstat.full;

   bgcd_front #(
      .WIDTH(WIDTH)
   ) u_front (
      .start         (start),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .qstat         (qstat),
      .push          (push),
      .job           (push_job)
   );

   bgcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   bgcd_back #(
      .WIDTH(WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_divisor (rsp_divisor)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the binary GCD block: drives operand words through the
// start/busy handshake and checks every divisor strobe against an in-bench Stein predictor.
// Depends on bgcd_pkg and binary_gcd.
module tb_top;
   import bgcd_pkg::FIELD_W;

   localparam int GCD_W       = 32;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_WORDS = 600;
   localparam int BURST_WORDS  = 100;
   localparam logic [63:0] OP_MASK = ~64'd0 >> (64 - GCD_W);

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [FIELD_W-1:0] req_operand_a;
   logic [FIELD_W-1:0] req_operand_b;
   logic               rsp_valid;
   logic [FIELD_W-1:0] rsp_divisor;

   logic [FIELD_W-1:0] expected_divisors[$];
   int                 mismatch_count = 0;
   int                 stall_cycles   = 0;
   bit                 idle_on        = 1'b1;

   binary_gcd #(.WIDTH(GCD_W)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid    (rsp_valid),
      .rsp_divisor  (rsp_divisor)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [FIELD_W-1:0] stein_divisor(input logic [FIELD_W-1:0] a,
                                                        input logic [FIELD_W-1:0] b);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] half_diff;
      int          twos;
      x    = {32'd0, a} & OP_MASK;
      y    = {32'd0, b} & OP_MASK;
      twos = 0;
      if (x == 0) return y[FIELD_W-1:0];
      if (y == 0) return x[FIELD_W-1:0];
      while (((x | y) & 64'd1) == 0) begin
         x = x >> 1;
         y = y >> 1;
         twos++;
      end
      while (x != 0) begin
         while (x != 0 && x[0] == 1'b0) x = x >> 1;
         while (y != 0 && y[0] == 1'b0) y = y >> 1;
         half_diff = ((x >= y) ? x - y : y - x) >> 1;
         if (x >= y) x = half_diff;
         else y = half_diff;
      end
      y = (y << twos) & OP_MASK;
      return y[FIELD_W-1:0];
   endfunction

   task automatic note_mismatch(input string what, input logic [FIELD_W-1:0] exp_word,
                                input logic [FIELD_W-1:0] act_word);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s divisor: expected %h, actual %h", $realtime, what, exp_word,
                  act_word);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_divisors.size() == 0) begin
            note_mismatch("unexpected", 'x, rsp_divisor);
         end else begin
            if (rsp_divisor !== expected_divisors[0])
               note_mismatch("wrong", expected_divisors[0], rsp_divisor);
            void'(expected_divisors.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_operands(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
      req_operand_a <= a;
      req_operand_b <= b;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_divisors.push_back(stein_divisor(a, b));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic test_zero_operands();
      send_operands(32'd0, 32'd0);
      send_operands(32'd0, 32'd12);
      send_operands(32'd40, 32'd0);
      send_operands(32'd0, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'd0);
      send_operands(32'd0, 32'h8000_0000);
   endtask

   task automatic test_extremes();
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'd1, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'd1);
      send_operands(32'd1, 32'd1);
      send_operands(32'h8000_0000, 32'h8000_0000);
      send_operands(32'h8000_0000, 32'hC000_0000);
      send_operands(32'h0000_0002, 32'h8000_0000);
      send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFC);
      send_operands(32'd4294967291, 32'd4294967279);
      send_operands(32'd2971215073, 32'd1836311903);
      send_operands(32'd1836311903, 32'd2971215073);
      send_operands(32'hAAAA_AAAA, 32'h5555_5555);
      send_operands(32'd48, 32'd180);
      send_operands(32'd180, 32'd48);
      send_operands(32'd12345678, 32'd12345678);
   endtask

   task automatic test_random_pairs(input int count);
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] g;
      int                 gbits;
      int                 twos;
      for (int i = 0; i < count; i++) begin
         a = $urandom;
         b = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6: begin
               gbits = $urandom_range(1, 24);
               twos  = $urandom_range(0, 8);
               g     = ($urandom & ((32'd1 << gbits) - 1)) | 32'd1;
               a     = (g * $urandom_range(1, (1 << (32 - gbits)) - 1)) << twos;
               b     = (g * $urandom_range(1, (1 << (32 - gbits)) - 1)) << twos;
            end
            7: begin
               a = a << $urandom_range(0, 31);
               b = b << $urandom_range(0, 31);
            end
            8: begin
               if ($urandom_range(0, 1) == 0) a = '0;
               else b = '0;
            end
            default: begin
               b = a + $urandom_range(0, 4) - 2;
            end
         endcase
         send_operands(a, b);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_operands();
      test_extremes();
      test_random_pairs(RANDOM_WORDS);
      idle_on = 1'b0;
      test_random_pairs(BURST_WORDS);
      start <= 1'b0;
      while (expected_divisors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
